FILE: src/bitmap_block_inode_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap block and inode allocator
// Each macro expands to one labelled concurrent assertion that is clocked by
// clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_INODE_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_INODE_ALLOCATOR_ASSERT_SVH

// The condition holds at every clock edge.
`define BBIA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("allocator invariant violated");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define BBIA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator same-cycle check failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define BBIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator next-cycle check failed");

`endif

FILE: src/bbia_pkg.sv
// ----------------------------------------------------------------------------
// bbia_pkg
// Shared widths, codes and default sizes of the bitmap allocator.
// ----------------------------------------------------------------------------
package bbia_pkg;

    // Default map geometry, handed to the top level as parameter defaults.
    localparam int INODE_MAP_BITS_DEF  = 1024;
    localparam int BLOCK_MAP_BITS_DEF  = 8192;
    localparam int BLOCKS_PER_FILE_DEF = 16;
    localparam int MAP_WORD_BITS_DEF   = 32;

    // Fixed field widths.
    localparam int COMMAND_W   = 2;
    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = 5;
    localparam int ALLOC_W     = 13;
    localparam int STATUS_W    = 2;
    localparam int LIMIT_W     = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
    localparam logic [INDEX_W-1:0] ROOT_RESET  = 10'd0;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_ALLOC_INODE = 2'd0,
        CMD_FREE_INODE  = 2'd1,
        CMD_ALLOC_BLOCK = 2'd2
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_INVALID  = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INODE_LIMIT = 1'b0,
        CFG_ROOT_INDEX  = 1'b1
    } cfg_reg_t;

endpackage

FILE: src/bbia_if.sv
// ----------------------------------------------------------------------------
// bbia_req_if / bbia_rsp_if
// Valid/ready channels for requests into and results out of the allocator.
// ----------------------------------------------------------------------------
interface bbia_req_if;
    logic                            valid;
    logic                            ready;
    logic [bbia_pkg::COMMAND_W-1:0]  command;
    logic [bbia_pkg::INDEX_W-1:0]    free_index;
    logic [bbia_pkg::COUNT_W-1:0]    file_block_count;

    modport source (output valid, command, free_index, file_block_count, input ready);
    modport sink   (input valid, command, free_index, file_block_count, output ready);
endinterface

interface bbia_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bbia_pkg::ALLOC_W-1:0]    alloc_index;
    logic [bbia_pkg::STATUS_W-1:0]   status;

    modport source (output valid, alloc_index, status, input ready);
    modport sink   (input valid, alloc_index, status, output ready);
endinterface

FILE: src/bbia_map_ram.sv
// ----------------------------------------------------------------------------
// bbia_map_ram
// One-read, one-write synchronous memory holding the rows of a free map.
// ----------------------------------------------------------------------------
module bbia_map_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read data is registered; a write and a read of the same row in the same
    // cycle return the old contents.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/bbia_first_zero.sv
// ----------------------------------------------------------------------------
// bbia_first_zero
// Finds the lowest clear bit of a map row among its first avail bits.
// ----------------------------------------------------------------------------
module bbia_first_zero #(
    parameter int WORD_BITS = 32,
    parameter int PW        = 5
) (
    input  logic [WORD_BITS-1:0] row,
    input  logic [PW:0]          avail,
    output logic                 found,
    output logic [PW-1:0]        pos
);

    // Scanned from the top so that the lowest qualifying bit wins.
    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!row[b] && ((PW + 1)'(b) < avail))
            begin
                found = 1'b1;
                pos   = PW'(b);
            end
        end
    end

endmodule

FILE: src/bitmap_block_inode_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_inode_allocator
// First-fit allocator over two bitmaps, one for inode numbers and one for
// data blocks, each held in a synchronous memory of map rows.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake     Payload
//  req      in         valid/ready   command, free_index, file_block_count
//  rsp      out        valid/ready   alloc_index, status
//  cfg      in         cfg_write     cfg_index, cfg_data (no stall)
//
// An allocation issues the read of the first row, examines the map rows in
// turn until a clear bit is found or the range ends, and then hands the result
// to the output register. A free walks row by row to the row of free_index,
// issues the read, writes the row back with the bit cleared and hands over the
// result; when its row has never been written it skips the read and the
// write-back. Invalid requests go straight to the result hand-over. The single
// read port of each map reads one row per cycle; one request is in flight at a
// time.
// After reset both maps read as all clear at once: a per-map high-water mark
// treats rows never written as zero, so no clearing pass is needed.
// A new request word is taken while a finished result word still waits in
// the output register; the result is held there until rsp.ready is seen.
// ----------------------------------------------------------------------------
`include "bitmap_block_inode_allocator_assert.svh"

module bitmap_block_inode_allocator #(
    parameter int INODE_MAP_BITS  = bbia_pkg::INODE_MAP_BITS_DEF,
    parameter int BLOCK_MAP_BITS  = bbia_pkg::BLOCK_MAP_BITS_DEF,
    parameter int BLOCKS_PER_FILE = bbia_pkg::BLOCKS_PER_FILE_DEF,
    parameter int MAP_WORD_BITS   = bbia_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bbia_req_if.sink                          req,
    bbia_rsp_if.source                        rsp,
    input  logic                              cfg_write,
    input  logic [bbia_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bbia_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Geometry derived from the parameters.
    localparam int W        = MAP_WORD_BITS;
    localparam int PW       = $clog2(W);
    localparam int IROWS    = (INODE_MAP_BITS + W - 1) / W;
    localparam int BROWS    = (BLOCK_MAP_BITS + W - 1) / W;
    localparam int IAW      = (IROWS > 1) ? $clog2(IROWS) : 1;
    localparam int BAW      = (BROWS > 1) ? $clog2(BROWS) : 1;
    localparam int MAXROWS  = (IROWS > BROWS) ? IROWS : BROWS;
    localparam int RCW      = $clog2(MAXROWS + 1);
    localparam int MAXBITS  = (INODE_MAP_BITS > BLOCK_MAP_BITS) ? INODE_MAP_BITS
                                                                : BLOCK_MAP_BITS;
    localparam int CW0      = $clog2(MAXBITS + 1);
    localparam int CW       = (CW0 > bbia_pkg::LIMIT_W) ? CW0 : bbia_pkg::LIMIT_W;
    localparam int IHW      = $clog2(IROWS + 1);
    localparam int BHW      = $clog2(BROWS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_SEEK,
        S_FREE_RMW,
        S_FINISH
    } state_t;

    state_t                           state_reg, state_next;
    logic                             sel_block_reg, sel_block_next;
    logic [RCW-1:0]                   row_reg, row_next;
    logic [CW-1:0]                    base_reg, base_next;
    logic [CW-1:0]                    rem_reg, rem_next;
    logic [bbia_pkg::ALLOC_W-1:0]     res_index_reg, res_index_next;
    bbia_pkg::status_t                res_status_reg, res_status_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    logic [bbia_pkg::ALLOC_W-1:0]     rsp_index_reg, rsp_index_next;
    bbia_pkg::status_t                rsp_status_reg, rsp_status_next;
    logic [bbia_pkg::LIMIT_W-1:0]     limit_reg, limit_next;
    logic [bbia_pkg::INDEX_W-1:0]     root_reg, root_next;
    logic [IHW-1:0]                   ino_hwm_reg, ino_hwm_next;
    logic [BHW-1:0]                   blk_hwm_reg, blk_hwm_next;

    // Memory ports.
    logic                             ino_rd_en, ino_wr_en;
    logic [IAW-1:0]                   ino_rd_addr;
    logic [W-1:0]                     ino_rd_data;
    logic                             blk_rd_en, blk_wr_en;
    logic [BAW-1:0]                   blk_rd_addr;
    logic [W-1:0]                     blk_rd_data;
    logic [W-1:0]                     wr_row;

    // Scan datapath.
    logic                             req_ready;
    logic [CW-1:0]                    limit_ext;
    logic [CW-1:0]                    inode_span;
    logic                             row_live;
    logic [W-1:0]                     cur_row;
    logic [PW:0]                      avail;
    logic                             hit_found;
    logic [PW-1:0]                    hit_pos;
    logic [CW-1:0]                    hit_index;
    logic [RCW-1:0]                   row_inc;

    bbia_map_ram #(
        .DEPTH (IROWS),
        .WIDTH (W),
        .AW    (IAW)
    ) u_inode_map (
        .clk     (clk),
        .rd_en   (ino_rd_en),
        .rd_addr (ino_rd_addr),
        .rd_data (ino_rd_data),
        .wr_en   (ino_wr_en),
        .wr_addr (row_reg[IAW-1:0]),
        .wr_data (wr_row)
    );

    bbia_map_ram #(
        .DEPTH (BROWS),
        .WIDTH (W),
        .AW    (BAW)
    ) u_block_map (
        .clk     (clk),
        .rd_en   (blk_rd_en),
        .rd_addr (blk_rd_addr),
        .rd_data (blk_rd_data),
        .wr_en   (blk_wr_en),
        .wr_addr (row_reg[BAW-1:0]),
        .wr_data (wr_row)
    );

    // The usable inode range is the smaller of the configured limit and the
    // map size.
    assign limit_ext  = CW'(limit_reg);
    assign inode_span = (limit_ext < CW'(INODE_MAP_BITS)) ? limit_ext : CW'(INODE_MAP_BITS);

    // A row at or above the high-water mark has never been written since
    // reset and therefore reads as all clear.
    assign row_live = sel_block_reg ? (row_reg < RCW'(blk_hwm_reg))
                                    : (row_reg < RCW'(ino_hwm_reg));
    assign cur_row  = row_live ? (sel_block_reg ? blk_rd_data : ino_rd_data) : '0;
    assign avail    = (rem_reg >= CW'(W)) ? (PW + 1)'(W) : rem_reg[PW:0];
    assign hit_index = base_reg + CW'(hit_pos);
    assign row_inc   = row_reg + 1'b1;

    bbia_first_zero #(
        .WORD_BITS (W),
        .PW        (PW)
    ) u_first_zero (
        .row   (cur_row),
        .avail (avail),
        .found (hit_found),
        .pos   (hit_pos)
    );

    always_comb
    begin
        state_next      = state_reg;
        sel_block_next  = sel_block_reg;
        row_next        = row_reg;
        base_next       = base_reg;
        rem_next        = rem_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_index_next  = rsp_index_reg;
        rsp_status_next = rsp_status_reg;
        limit_next      = limit_reg;
        root_next       = root_reg;
        ino_hwm_next    = ino_hwm_reg;
        blk_hwm_next    = blk_hwm_reg;

        ino_rd_en   = 1'b0;
        ino_rd_addr = row_reg[IAW-1:0];
        blk_rd_en   = 1'b0;
        blk_rd_addr = row_reg[BAW-1:0];
        ino_wr_en   = 1'b0;
        blk_wr_en   = 1'b0;
        wr_row      = cur_row | (W'(1) << hit_pos);
        req_ready   = (state_reg == S_IDLE);

        // Users must write configuration only while the block is idle; not enforced.
        if (cfg_write)
        begin
            case (cfg_index)
                bbia_pkg::CFG_INODE_LIMIT: limit_next = cfg_data[bbia_pkg::LIMIT_W-1:0];
                bbia_pkg::CFG_ROOT_INDEX:  root_next  = cfg_data[bbia_pkg::INDEX_W-1:0];
                default: ;
            endcase
        end

        // The output register empties when its word is taken.
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    row_next        = '0;
                    base_next       = '0;
                    res_index_next  = '0;
                    res_status_next = bbia_pkg::ST_OK;
                    state_next      = S_FINISH;
                    case (req.command)
                        bbia_pkg::CMD_ALLOC_INODE:
                        begin
                            sel_block_next = 1'b0;
                            if (inode_span == '0)
                            begin
                                res_status_next = bbia_pkg::ST_NO_SPACE;
                            end
                            else
                            begin
                                rem_next    = inode_span;
                                ino_rd_en   = 1'b1;
                                ino_rd_addr = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        bbia_pkg::CMD_FREE_INODE:
                        begin
                            if (req.free_index == root_reg)
                            begin
                                res_status_next = bbia_pkg::ST_INVALID;
                            end
                            else if (CW'(req.free_index) < CW'(INODE_MAP_BITS))
                            begin
                                // rem_reg carries the bit offset during the row walk.
                                rem_next   = CW'(req.free_index);
                                state_next = S_FREE_SEEK;
                            end
                        end
                        bbia_pkg::CMD_ALLOC_BLOCK:
                        begin
                            if (CW'(req.file_block_count) >= CW'(BLOCKS_PER_FILE))
                            begin
                                res_status_next = bbia_pkg::ST_INVALID;
                            end
                            else
                            begin
                                sel_block_next = 1'b1;
                                rem_next       = CW'(BLOCK_MAP_BITS);
                                blk_rd_en      = 1'b1;
                                blk_rd_addr    = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_next = bbia_pkg::ST_INVALID;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (hit_found)
                begin
                    // Mark the bit taken and raise the high-water mark.
                    if (sel_block_reg)
                    begin
                        blk_wr_en = 1'b1;
                        if (RCW'(blk_hwm_reg) <= row_reg)
                        begin
                            blk_hwm_next = BHW'(row_inc);
                        end
                    end
                    else
                    begin
                        ino_wr_en = 1'b1;
                        if (RCW'(ino_hwm_reg) <= row_reg)
                        begin
                            ino_hwm_next = IHW'(row_inc);
                        end
                    end
                    res_index_next  = bbia_pkg::ALLOC_W'(hit_index);
                    res_status_next = bbia_pkg::ST_OK;
                    state_next      = S_FINISH;
                end
                else if (rem_reg <= CW'(W))
                begin
                    res_index_next  = '0;
                    res_status_next = bbia_pkg::ST_NO_SPACE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    rem_next  = rem_reg - CW'(W);
                    base_next = base_reg + CW'(W);
                    row_next  = row_inc;
                    if (sel_block_reg)
                    begin
                        blk_rd_en   = 1'b1;
                        blk_rd_addr = row_inc[BAW-1:0];
                    end
                    else
                    begin
                        ino_rd_en   = 1'b1;
                        ino_rd_addr = row_inc[IAW-1:0];
                    end
                end
            end

            S_FREE_SEEK:
            begin
                if (rem_reg >= CW'(W))
                begin
                    rem_next = rem_reg - CW'(W);
                    row_next = row_inc;
                end
                else if (row_reg < RCW'(ino_hwm_reg))
                begin
                    ino_rd_en   = 1'b1;
                    ino_rd_addr = row_reg[IAW-1:0];
                    state_next  = S_FREE_RMW;
                end
                else
                begin
                    // Never written since reset, so the bit is already clear.
                    state_next = S_FINISH;
                end
            end

            S_FREE_RMW:
            begin
                wr_row     = ino_rd_data & ~(W'(1) << rem_reg[PW-1:0]);
                ino_wr_en  = 1'b1;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_index_next  = res_index_reg;
                    rsp_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sel_block_reg  <= 1'b0;
            row_reg        <= '0;
            base_reg       <= '0;
            rem_reg        <= '0;
            res_index_reg  <= '0;
            res_status_reg <= bbia_pkg::ST_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_index_reg  <= '0;
            rsp_status_reg <= bbia_pkg::ST_OK;
            limit_reg      <= bbia_pkg::LIMIT_RESET;
            root_reg       <= bbia_pkg::ROOT_RESET;
            ino_hwm_reg    <= '0;
            blk_hwm_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sel_block_reg  <= sel_block_next;
            row_reg        <= row_next;
            base_reg       <= base_next;
            rem_reg        <= rem_next;
            res_index_reg  <= res_index_next;
            res_status_reg <= res_status_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_index_reg  <= rsp_index_next;
            rsp_status_reg <= rsp_status_next;
            limit_reg      <= limit_next;
            root_reg       <= root_next;
            ino_hwm_reg    <= ino_hwm_next;
            blk_hwm_reg    <= blk_hwm_next;
        end
    end

    assign req.ready       = req_ready;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.alloc_index = rsp_index_reg;
    assign rsp.status      = rsp_status_reg;

    // A scan always has at least one bit of range left to examine.
    `BBIA_ASSERT_SAME(a_scan_has_range, state_reg == S_SCAN, rem_reg != '0)
    // Only one of the two maps is modified in any cycle.
    `BBIA_ASSERT_ALWAYS(a_single_map_write, !(ino_wr_en && blk_wr_en))
    // A write-back is the last memory step of a request.
    `BBIA_ASSERT_NEXT(a_write_ends_request, ino_wr_en || blk_wr_en, state_reg == S_FINISH)
    // A result leaving the finish state lands in the output register.
    `BBIA_ASSERT_NEXT(a_finish_loads_output,
        state_reg == S_FINISH && (!rsp_valid_reg || rsp.ready),
        rsp_valid_reg && state_reg == S_IDLE)

endmodule

FILE: bench/tb_bitmap_block_inode_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_block_inode_allocator
// Self-checking bench for the bitmap inode and data block allocator. Request
// words are driven on the req channel and result words are checked on the rsp
// channel against a behavioural copy of both free maps. Idle gaps are
// inserted at random on both sides. Runs cover directed corner cases,
// inode map exhaustion, several register settings and a long run of block
// allocations without idle cycles.
// ----------------------------------------------------------------------------
module tb_bitmap_block_inode_allocator;

    // Map geometry of the instance under test (the package defaults).
    localparam int INODE_BITS     = bbia_pkg::INODE_MAP_BITS_DEF;
    localparam int BLOCK_BITS     = bbia_pkg::BLOCK_MAP_BITS_DEF;
    localparam int FILE_BLOCKS    = bbia_pkg::BLOCKS_PER_FILE_DEF;
    localparam int ROW_BITS       = bbia_pkg::MAP_WORD_BITS_DEF;
    localparam int INODE_ROWS     = INODE_BITS / ROW_BITS;
    localparam int BLOCK_ROWS     = BLOCK_BITS / ROW_BITS;

    // Command code 3 has no meaning and must be refused as invalid.
    localparam logic [bbia_pkg::COMMAND_W-1:0] CMD_UNKNOWN = 2'd3;

    // Percentage of cycles in which a side idles while idling is enabled.
    localparam int IDLE_PCT       = 30;
    // Cycles without any accepted word before the run is abandoned. The
    // slowest request is a scan of the whole block map.
    localparam int QUIET_LIMIT    = 10000;
    // Cycles allowed for stray words after the last expected result.
    localparam int TAIL_CYCLES    = 300;
    // Block requests sent back to back in the stretch without idling.
    localparam int BLOCK_RUN      = 250;

    typedef struct packed {
        logic [bbia_pkg::ALLOC_W-1:0] alloc_index;
        bbia_pkg::status_t            status;
    } grant_t;

    logic clk;
    logic rst_n;
    logic                             cfg_write;
    logic [bbia_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bbia_pkg::CFG_DATA_W-1:0]  cfg_data;

    bbia_req_if req_ch ();
    bbia_rsp_if rsp_ch ();

    bitmap_block_inode_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the allocator state, updated as each request word is
    // accepted. Rows hold the map in the same bit order as the block.
    logic [ROW_BITS-1:0]          inode_rows [INODE_ROWS];
    logic [ROW_BITS-1:0]          block_rows [BLOCK_ROWS];
    logic [bbia_pkg::LIMIT_W-1:0] limit_shadow;
    logic [bbia_pkg::INDEX_W-1:0] root_shadow;

    // Results still owed by the block, oldest first.
    grant_t pending_grants [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    bit idle_enabled   = 1'b1;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------

    // Claims the lowest clear bit below span in one of the two maps. A row
    // that is completely set is skipped whole, which keeps the search cheap
    // once the block map has filled up.
    function automatic bit take_first_free(input bit in_block_map, input int span,
                                           output int found);
        int                  row;
        int                  pos;
        int                  idx;
        logic [ROW_BITS-1:0] bits;
        found = 0;
        for (row = 0; row * ROW_BITS < span; row++)
        begin
            bits = in_block_map ? block_rows[row] : inode_rows[row];
            if (!(&bits))
            begin
                for (pos = 0; pos < ROW_BITS; pos++)
                begin
                    idx = row * ROW_BITS + pos;
                    if (idx >= span)
                        return 1'b0;
                    if (!bits[pos])
                    begin
                        if (in_block_map)
                            block_rows[row][pos] = 1'b1;
                        else
                            inode_rows[row][pos] = 1'b1;
                        found = idx;
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to the shadow maps and returns the result word
    // the block must produce for it.
    function automatic grant_t predict_allocation(
        input logic [bbia_pkg::COMMAND_W-1:0] command,
        input logic [bbia_pkg::INDEX_W-1:0]   free_index,
        input logic [bbia_pkg::COUNT_W-1:0]   block_count);
        grant_t outcome;
        int     span;
        int     found;
        outcome.alloc_index = '0;
        outcome.status      = bbia_pkg::ST_OK;
        case (command)
            bbia_pkg::CMD_ALLOC_INODE:
            begin
                // Limits above the map size behave as the map size.
                span = (limit_shadow < INODE_BITS) ? int'(limit_shadow) : INODE_BITS;
                if (take_first_free(1'b0, span, found))
                    outcome.alloc_index = found[bbia_pkg::ALLOC_W-1:0];
                else
                    outcome.status = bbia_pkg::ST_NO_SPACE;
            end
            bbia_pkg::CMD_FREE_INODE:
            begin
                if (free_index == root_shadow)
                    outcome.status = bbia_pkg::ST_INVALID;
                else
                    inode_rows[free_index / ROW_BITS][free_index % ROW_BITS] = 1'b0;
            end
            bbia_pkg::CMD_ALLOC_BLOCK:
            begin
                if (block_count >= FILE_BLOCKS)
                    outcome.status = bbia_pkg::ST_INVALID;
                else if (take_first_free(1'b1, BLOCK_BITS, found))
                    outcome.alloc_index = found[bbia_pkg::ALLOC_W-1:0];
                else
                    outcome.status = bbia_pkg::ST_NO_SPACE;
            end
            default:
                outcome.status = bbia_pkg::ST_INVALID;
        endcase
        return outcome;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------

    // Drives one request word, optionally after a random idle gap, and waits
    // until it is accepted. The expected result is queued at the accepting
    // edge, so the shadow maps follow the exact order the block sees.
    task automatic send_request(input  logic [bbia_pkg::COMMAND_W-1:0] command,
                                input  logic [bbia_pkg::INDEX_W-1:0]   free_index,
                                input  logic [bbia_pkg::COUNT_W-1:0]   block_count,
                                output grant_t                         predicted);
        @(negedge clk);
        while (idle_enabled && ($urandom_range(99) < IDLE_PCT))
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid            = 1'b1;
        req_ch.command          = command;
        req_ch.free_index       = free_index;
        req_ch.file_block_count = block_count;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = predict_allocation(command, free_index, block_count);
        pending_grants.push_back(predicted);
    endtask

    // Lowers valid and lets every outstanding result drain, then lets the
    // clock run on before any register is written.
    task automatic wait_until_idle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input bbia_pkg::cfg_reg_t target,
                                  input logic [bbia_pkg::CFG_DATA_W-1:0] value);
        wait_until_idle();
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = target;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        // The shadow registers keep only as many bits as the block does.
        if (target == bbia_pkg::CFG_INODE_LIMIT)
            limit_shadow = value[bbia_pkg::LIMIT_W-1:0];
        else
            root_shadow = value[bbia_pkg::INDEX_W-1:0];
    endtask

    // One request of a random kind. Unused fields always carry random noise;
    // frees lean towards the low indexes where allocated inodes sit.
    task automatic send_random_request(input int inode_pct, input int free_pct,
                                       input int block_pct);
        int                                 roll;
        logic [bbia_pkg::INDEX_W-1:0]       free_index;
        logic [bbia_pkg::COUNT_W-1:0]       block_count;
        grant_t                             predicted;
        roll        = $urandom_range(99);
        free_index  = bbia_pkg::INDEX_W'($urandom_range(INODE_BITS - 1));
        block_count = bbia_pkg::COUNT_W'($urandom_range((1 << bbia_pkg::COUNT_W) - 1));
        if (roll < inode_pct)
            send_request(bbia_pkg::CMD_ALLOC_INODE, free_index, block_count, predicted);
        else if (roll < inode_pct + free_pct)
        begin
            if ($urandom_range(1))
                free_index = bbia_pkg::INDEX_W'($urandom_range(63));
            send_request(bbia_pkg::CMD_FREE_INODE, free_index, block_count, predicted);
        end
        else if (roll < inode_pct + free_pct + block_pct)
        begin
            if ($urandom_range(99) < 80)
                block_count = bbia_pkg::COUNT_W'($urandom_range(FILE_BLOCKS - 1));
            send_request(bbia_pkg::CMD_ALLOC_BLOCK, free_index, block_count, predicted);
        end
        else
            send_request(CMD_UNKNOWN, free_index, block_count, predicted);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, every command and each corner case, in a fixed order
    // from the reset state (limit 1024, root inode 0).
    task automatic test_directed_cases();
        grant_t predicted;
        send_request(bbia_pkg::CMD_ALLOC_INODE, 10'd0, 5'd0, predicted);
        send_request(bbia_pkg::CMD_ALLOC_INODE, 10'd1023, 5'd31, predicted);
        // The root inode may never be released.
        send_request(bbia_pkg::CMD_FREE_INODE, 10'd0, 5'd0, predicted);
        send_request(bbia_pkg::CMD_FREE_INODE, 10'd1, 5'd31, predicted);
        // Releasing an inode that is already free is harmless.
        send_request(bbia_pkg::CMD_FREE_INODE, 10'd1, 5'd0, predicted);
        send_request(bbia_pkg::CMD_ALLOC_INODE, 10'd0, 5'd0, predicted);
        send_request(bbia_pkg::CMD_FREE_INODE, 10'd1023, 5'd0, predicted);
        // Data blocks: lowest and highest legal counts, then a full file.
        send_request(bbia_pkg::CMD_ALLOC_BLOCK, 10'd1023, 5'd0, predicted);
        send_request(bbia_pkg::CMD_ALLOC_BLOCK, 10'd0, 5'd15, predicted);
        send_request(bbia_pkg::CMD_ALLOC_BLOCK, 10'd0, 5'd16, predicted);
        send_request(bbia_pkg::CMD_ALLOC_BLOCK, 10'd1023, 5'd31, predicted);
        // The undefined command code changes nothing.
        send_request(CMD_UNKNOWN, 10'd1023, 5'd31, predicted);
        send_request(CMD_UNKNOWN, 10'd0, 5'd0, predicted);
        // No inode is usable at all with a zero limit.
        write_register(bbia_pkg::CFG_INODE_LIMIT, 11'd0);
        send_request(bbia_pkg::CMD_ALLOC_INODE, 10'd0, 5'd0, predicted);
        // Inodes 0 and 1 are taken, so a limit of 2 leaves nothing free.
        write_register(bbia_pkg::CFG_INODE_LIMIT, 11'd2);
        send_request(bbia_pkg::CMD_ALLOC_INODE, 10'd0, 5'd0, predicted);
        write_register(bbia_pkg::CFG_INODE_LIMIT, 11'd3);
        send_request(bbia_pkg::CMD_ALLOC_INODE, 10'd0, 5'd0, predicted);
        // Move the root to the top index; inode 0 becomes releasable.
        write_register(bbia_pkg::CFG_ROOT_INDEX, 11'd1023);
        send_request(bbia_pkg::CMD_FREE_INODE, 10'd1023, 5'd0, predicted);
        send_request(bbia_pkg::CMD_FREE_INODE, 10'd0, 5'd0, predicted);
        send_request(bbia_pkg::CMD_ALLOC_INODE, 10'd0, 5'd0, predicted);
        // A limit beyond the map is clipped to the map size.
        write_register(bbia_pkg::CFG_INODE_LIMIT, 11'd2047);
        send_request(bbia_pkg::CMD_ALLOC_INODE, 10'd0, 5'd0, predicted);
        write_register(bbia_pkg::CFG_ROOT_INDEX, 11'(bbia_pkg::ROOT_RESET));
        write_register(bbia_pkg::CFG_INODE_LIMIT, bbia_pkg::LIMIT_RESET);
    endtask

    // Allocates inodes until the whole map is in use and a few requests have
    // been refused, then churns the full map with frees and allocations.
    task automatic test_inode_exhaustion();
        grant_t predicted;
        int     refusals;
        int     n;
        refusals = 0;
        while (refusals < 4)
        begin
            send_request(bbia_pkg::CMD_ALLOC_INODE, bbia_pkg::INDEX_W'($urandom),
                         bbia_pkg::COUNT_W'($urandom), predicted);
            if (predicted.status == bbia_pkg::ST_NO_SPACE)
                refusals++;
        end
        for (n = 0; n < 60; n++)
            send_random_request(45, 45, 5);
    endtask

    // Random traffic under a range of limit and root settings, the extremes
    // among them. The inode map carries over from one setting to the next.
    task automatic test_register_settings();
        logic [bbia_pkg::CFG_DATA_W-1:0] limits [6];
        logic [bbia_pkg::CFG_DATA_W-1:0] roots  [6];
        int                              phase;
        int                              n;
        limits = '{11'd1024, 11'd37, 11'd1, 11'd0, 11'd700, 11'd2047};
        roots  = '{11'd0, 11'd5, 11'd1023, 11'd512, 11'($urandom_range(1023)),
                   11'($urandom_range(63))};
        for (phase = 0; phase < 6; phase++)
        begin
            write_register(bbia_pkg::CFG_INODE_LIMIT, limits[phase]);
            write_register(bbia_pkg::CFG_ROOT_INDEX, roots[phase]);
            for (n = 0; n < 50; n++)
                send_random_request(30, 30, 30);
        end
        write_register(bbia_pkg::CFG_ROOT_INDEX, 11'(bbia_pkg::ROOT_RESET));
        write_register(bbia_pkg::CFG_INODE_LIMIT, bbia_pkg::LIMIT_RESET);
    endtask

    // Block requests back to back with both sides always ready. This is the
    // long stretch without idle cycles; about one request in ten names a full
    // file and must be refused.
    task automatic test_block_allocation();
        grant_t                       predicted;
        int                           n;
        logic [bbia_pkg::COUNT_W-1:0] block_count;
        idle_enabled = 1'b0;
        for (n = 0; n < BLOCK_RUN; n++)
        begin
            if ($urandom_range(99) < 10)
                block_count = bbia_pkg::COUNT_W'(
                    $urandom_range((1 << bbia_pkg::COUNT_W) - 1, FILE_BLOCKS));
            else
                block_count = bbia_pkg::COUNT_W'($urandom_range(FILE_BLOCKS - 1));
            send_request(bbia_pkg::CMD_ALLOC_BLOCK, bbia_pkg::INDEX_W'($urandom),
                         block_count, predicted);
        end
        idle_enabled = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the scoreboard check
    // ------------------------------------------------------------------------

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = !idle_enabled || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Every accepted result word is compared with the oldest expectation.
    always @(posedge clk)
    begin
        grant_t owed;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_grants.size() == 0)
            begin
                $error("result word with nothing outstanding: alloc_index %0d status %0d",
                       rsp_ch.alloc_index, rsp_ch.status);
                mismatch_count++;
            end
            else
            begin
                owed = pending_grants.pop_front();
                if (rsp_ch.alloc_index !== owed.alloc_index)
                begin
                    $error("alloc_index: expected %0d, got %0d",
                           owed.alloc_index, rsp_ch.alloc_index);
                    mismatch_count++;
                end
                if (rsp_ch.status !== owed.status)
                begin
                    $error("status: expected %0d, got %0d", owed.status, rsp_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a run in which no word moves on either channel for too long
    // has hung and is ended as a failure.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------

    initial
    begin
        int row;
        // Every input is known from time zero.
        rst_n                   = 1'b0;
        cfg_write               = 1'b0;
        cfg_index               = bbia_pkg::CFG_INODE_LIMIT;
        cfg_data                = '0;
        req_ch.valid            = 1'b0;
        req_ch.command          = bbia_pkg::CMD_ALLOC_INODE;
        req_ch.free_index       = '0;
        req_ch.file_block_count = '0;

        // Both maps start all clear with the registers at their reset values.
        for (row = 0; row < INODE_ROWS; row++)
            inode_rows[row] = '0;
        for (row = 0; row < BLOCK_ROWS; row++)
            block_rows[row] = '0;
        limit_shadow = bbia_pkg::LIMIT_RESET;
        root_shadow  = bbia_pkg::ROOT_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_inode_exhaustion();
        test_register_settings();
        test_block_allocation();

        // Drain, then watch a little longer for any result word nobody asked for.
        wait_until_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/bbia_pkg.sv
src/bbia_if.sv
src/bbia_map_ram.sv
src/bbia_first_zero.sv
src/bitmap_block_inode_allocator.sv
bench/tb_bitmap_block_inode_allocator.sv
